### hw/rtl/h264nal_pkg.sv
// shared types and constants for the annex b nal locator
package h264nal_pkg;

  localparam int POS_W = 20;

  localparam logic [7:0] BYTE_ZERO = 8'h00;
  localparam logic [7:0] BYTE_ONE  = 8'h01;

  localparam logic [4:0] NAL_IDR = 5'd5;
  localparam logic [4:0] NAL_SPS = 5'd7;
  localparam logic [4:0] NAL_PPS = 5'd8;

  localparam logic STATUS_IDR  = 1'b0;
  localparam logic STATUS_NONE = 1'b1;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_SPS  = 2'd1,
    KIND_PPS  = 2'd2
  } kind_t;

  typedef struct packed {
    logic             status;
    logic [POS_W-1:0] idr_pos;
    logic             sps_found;
    logic [POS_W-1:0] sps_pos;
    logic [POS_W-1:0] sps_len;
    logic             pps_found;
    logic [POS_W-1:0] pps_pos;
    logic [POS_W-1:0] pps_len;
  } summary_t;

endpackage

### hw/rtl/h264_annexb_nal_locator.sv
// top level of the annex b nal locator
//
// in_*: one byte of an annex b frame per word, in_last_byte on the final
// byte. out_*: at most one summary word per frame. It is given at the
// first idr header (status 0, idr_pos set) or at the final byte when the
// frame held no idr (status 1). It carries the latest sps and pps header
// offsets and their lengths up to the following start code.
// Throughput is one byte per cycle while the output word is not stalled. A
// byte passes an input register and is scanned into the output register,
// from which the summary that it caused shows on out_valid.
// Bytes after an idr header are taken and dropped until in_last_byte.
// When the output word is stalled, the byte in the input register waits
// (one more is taken first if that register was empty) and in_stall
// stays high until the word is taken.
// Reset (rst_n low, synchronous) empties both registers and starts a new
// frame at offset zero. Every frame end also returns the scanner to that
// state. Offsets saturate at MAX_FRAME_BYTES; later bytes are ignored
// except for in_last_byte.
module h264_annexb_nal_locator import h264nal_pkg::*; #(
  parameter int MAX_FRAME_BYTES = 1048576
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_data_byte,
  input  logic             in_last_byte,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_status,
  output logic [POS_W-1:0] out_idr_pos,
  output logic             out_sps_found,
  output logic [POS_W-1:0] out_sps_pos,
  output logic [POS_W-1:0] out_sps_len,
  output logic             out_pps_found,
  output logic [POS_W-1:0] out_pps_pos,
  output logic [POS_W-1:0] out_pps_len
);

  logic     hold;
  logic     s1_valid;
  logic     res_valid;
  summary_t res;
  summary_t out_word;

  assign in_stall = s1_valid && hold;

  h264nal_scan #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_scan (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .hold         (hold),
    .s1_valid     (s1_valid),
    .res_valid    (res_valid),
    .res          (res)
  );

  h264nal_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .out_stall (out_stall),
    .hold      (hold),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  assign out_status    = out_word.status;
  assign out_idr_pos   = out_word.idr_pos;
  assign out_sps_found = out_word.sps_found;
  assign out_sps_pos   = out_word.sps_pos;
  assign out_sps_len   = out_word.sps_len;
  assign out_pps_found = out_word.pps_found;
  assign out_pps_pos   = out_word.pps_pos;
  assign out_pps_len   = out_word.pps_len;

  // input side only backs up while the output word is stuck
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall without a stalled output word");

  a_no_idr_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STATUS_NONE) |-> (out_idr_pos == '0))
    else $error("not-found summary carries an idr offset");

  a_sps_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_sps_found) |-> (out_sps_pos == '0 && out_sps_len == '0))
    else $error("sps fields set without an sps header");

  a_pps_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_pps_found) |-> (out_pps_pos == '0 && out_pps_len == '0))
    else $error("pps fields set without a pps header");

endmodule

### hw/rtl/h264nal_scan.sv
// input register and per-byte start code / nal header scanner
module h264nal_scan import h264nal_pkg::*; #(
  parameter int MAX_FRAME_BYTES = 1048576
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_stall,
  input  logic [7:0] in_data_byte,
  input  logic     in_last_byte,
  input  logic     hold,
  output logic     s1_valid,
  output logic     res_valid,
  output summary_t res
);

  localparam int OFFS_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam logic [OFFS_W-1:0] MAX_OFFS = OFFS_W'(MAX_FRAME_BYTES);

  logic             s1_valid_r;
  logic [7:0]       s1_data_r;
  logic             s1_last_r;

  logic [OFFS_W-1:0] offset_r, offset_nxt;
  logic [1:0]        zrun_r, zrun_nxt;
  logic              hdr_r, hdr_nxt;
  logic              code4_r, code4_nxt;
  kind_t             pend_r, pend_nxt;
  logic              sps_fnd_r, sps_fnd_nxt;
  logic [POS_W-1:0]  sps_pos_r, sps_pos_nxt;
  logic [POS_W-1:0]  sps_len_r, sps_len_nxt;
  logic              pps_fnd_r, pps_fnd_nxt;
  logic [POS_W-1:0]  pps_pos_r, pps_pos_nxt;
  logic [POS_W-1:0]  pps_len_r, pps_len_nxt;
  logic              skip_r, skip_nxt;

  logic                    go;
  logic                    in_range;
  logic [OFFS_W+POS_W-1:0] offset_ext;
  logic [POS_W-1:0]        here;
  logic [POS_W-1:0]        code_start;
  logic [4:0]              nal_type;

  assign s1_valid   = s1_valid_r;
  assign go         = s1_valid_r && !hold;
  assign in_range   = offset_r < MAX_OFFS;
  assign offset_ext = {{POS_W{1'b0}}, offset_r};
  assign here       = offset_ext[POS_W-1:0];
  assign code_start = here - (code4_r ? POS_W'(4) : POS_W'(3));
  assign nal_type   = s1_data_r[4:0];

  always_comb begin
    offset_nxt  = offset_r;
    zrun_nxt    = zrun_r;
    hdr_nxt     = hdr_r;
    code4_nxt   = code4_r;
    pend_nxt    = pend_r;
    sps_fnd_nxt = sps_fnd_r;
    sps_pos_nxt = sps_pos_r;
    sps_len_nxt = sps_len_r;
    pps_fnd_nxt = pps_fnd_r;
    pps_pos_nxt = pps_pos_r;
    pps_len_nxt = pps_len_r;
    skip_nxt    = skip_r;
    res_valid   = 1'b0;
    res         = '0;

    if (!skip_r && in_range) begin
      if (hdr_r) begin
        hdr_nxt = 1'b0;
        // close the previous sps/pps at the start of this code
        case (pend_r)
          KIND_SPS: sps_len_nxt = code_start - sps_pos_r;
          KIND_PPS: pps_len_nxt = code_start - pps_pos_r;
          default:  ;
        endcase
        pend_nxt = KIND_NONE;
        if (nal_type == NAL_IDR) begin
          res_valid = go;
          skip_nxt  = 1'b1;
        end else if (nal_type == NAL_SPS) begin
          sps_fnd_nxt = 1'b1;
          sps_pos_nxt = here;
          pend_nxt    = KIND_SPS;
        end else if (nal_type == NAL_PPS) begin
          pps_fnd_nxt = 1'b1;
          pps_pos_nxt = here;
          pend_nxt    = KIND_PPS;
        end
      end
      if (!skip_nxt) begin
        if (s1_data_r == BYTE_ZERO) begin
          if (zrun_r != 2'd3) begin
            zrun_nxt = zrun_r + 2'd1;
          end
        end else if (s1_data_r == BYTE_ONE && zrun_r[1]) begin
          hdr_nxt   = 1'b1;
          code4_nxt = (zrun_r == 2'd3);
          zrun_nxt  = 2'd0;
        end else begin
          zrun_nxt = 2'd0;
        end
      end
    end

    if (in_range) begin
      offset_nxt = offset_r + OFFS_W'(1);
    end

    res.status    = res_valid ? STATUS_IDR : STATUS_NONE;
    res.idr_pos   = res_valid ? here : '0;
    res.sps_found = sps_fnd_nxt;
    res.sps_pos   = sps_pos_nxt;
    res.sps_len   = sps_len_nxt;
    res.pps_found = pps_fnd_nxt;
    res.pps_pos   = pps_pos_nxt;
    res.pps_len   = pps_len_nxt;

    if (s1_last_r) begin
      // at frame end give the not-found summary if no idr was seen, and reset
      if (!res_valid && !skip_nxt) begin
        res_valid = go;
      end
      offset_nxt  = '0;
      zrun_nxt    = 2'd0;
      hdr_nxt     = 1'b0;
      code4_nxt   = 1'b1;
      pend_nxt    = KIND_NONE;
      sps_fnd_nxt = 1'b0;
      sps_pos_nxt = '0;
      sps_len_nxt = '0;
      pps_fnd_nxt = 1'b0;
      pps_pos_nxt = '0;
      pps_len_nxt = '0;
      skip_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
    if (in_valid && !in_stall) begin
      s1_data_r <= in_data_byte;
      s1_last_r <= in_last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r  <= '0;
      zrun_r    <= 2'd0;
      hdr_r     <= 1'b0;
      code4_r   <= 1'b1;
      pend_r    <= KIND_NONE;
      sps_fnd_r <= 1'b0;
      sps_pos_r <= '0;
      sps_len_r <= '0;
      pps_fnd_r <= 1'b0;
      pps_pos_r <= '0;
      pps_len_r <= '0;
      skip_r    <= 1'b0;
    end else if (go) begin
      offset_r  <= offset_nxt;
      zrun_r    <= zrun_nxt;
      hdr_r     <= hdr_nxt;
      code4_r   <= code4_nxt;
      pend_r    <= pend_nxt;
      sps_fnd_r <= sps_fnd_nxt;
      sps_pos_r <= sps_pos_nxt;
      sps_len_r <= sps_len_nxt;
      pps_fnd_r <= pps_fnd_nxt;
      pps_pos_r <= pps_pos_nxt;
      pps_len_r <= pps_len_nxt;
      skip_r    <= skip_nxt;
    end
  end

endmodule

### hw/rtl/h264nal_obuf.sv
// output register for the summary word
module h264nal_obuf import h264nal_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     res_valid,
  input  summary_t res,
  input  logic     out_stall,
  output logic     hold,
  output logic     out_valid,
  output summary_t out_word
);

  logic     out_valid_r;
  summary_t out_word_r;

  // the register is busy only while a word sits in it and is stalled
  assign hold      = out_valid_r && out_stall;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!hold) begin
      out_valid_r <= res_valid;
    end
    if (res_valid && !hold) begin
      out_word_r <= res;
    end
  end

endmodule
